@@ hdl/hhcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hhcs_pkg;

	localparam int ARMS          = 2;
	localparam int GAPS          = 5;
	localparam int PANELS        = 6;
	localparam int ORIENTS       = 2;
	localparam int VALUE_BINS    = 66;
	localparam int BINS_PER_HIST = VALUE_BINS + 1;
	localparam int COUNT_BITS    = 32;
	localparam int H_PER_GAP     = 16;
	localparam int V_PER_GAP     = 14;
	localparam int NO_EDGE       = 65;

	localparam int CHAINS_PER_ARM = GAPS * (H_PER_GAP + V_PER_GAP);
	localparam int BIN_DEPTH      = ARMS * GAPS * PANELS * ORIENTS * BINS_PER_HIST;
	localparam int CHAIN_DEPTH    = ARMS * CHAINS_PER_ARM;
	localparam int BIN_AW         = $clog2(BIN_DEPTH);
	localparam int CHAIN_AW       = $clog2(CHAIN_DEPTH);

	// first value of the second and third chain of a panel
	localparam int EDGE_A [ORIENTS][PANELS] = '{
		'{19, NO_EDGE, 19, 20, NO_EDGE, 20},
		'{22, NO_EDGE, 22, 22, NO_EDGE, 22}
	};
	localparam int EDGE_B [ORIENTS][PANELS] = '{
		'{39, 23, 39, 40, 23, 40},
		'{44, NO_EDGE, 44, 44, NO_EDGE, 44}
	};
	localparam int PANEL_BASE [ORIENTS][PANELS] = '{
		'{0, 3, 5, 8, 11, 13},
		'{0, 3, 4, 7, 10, 11}
	};
	localparam int PER_GAP [ORIENTS] = '{H_PER_GAP, V_PER_GAP};

	typedef enum logic [1:0] {
		ACT_HIT   = 2'd0,
		ACT_BIN   = 2'd1,
		ACT_CHAIN = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		logic [1:0] action;
		logic       arm;
		logic [2:0] gap;
		logic [2:0] panel;
		logic       orient;
		logic [6:0] pack_value;
		logic [6:0] bin_index;
		logic [6:0] chain_index;
	} item_t;

	typedef struct packed {
		logic [BIN_AW-1:0]   bin_addr;
		logic                bin_ok;
		logic [CHAIN_AW-1:0] chain_addr;
		logic                chain_ok;
	} slot_t;

endpackage
`default_nettype wire

@@ hdl/hhcs_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface hhcs_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic       arm;
	logic [2:0] gap;
	logic [2:0] panel;
	logic       orient;
	logic [6:0] pack_value;
	logic [6:0] bin_index;
	logic [6:0] chain_index;

	modport source (
		output valid, action, arm, gap, panel, orient, pack_value, bin_index, chain_index,
		input  ready
	);
	modport sink (
		input  valid, action, arm, gap, panel, orient, pack_value, bin_index, chain_index,
		output ready
	);
endinterface
`default_nettype wire

@@ hdl/hhcs_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface hhcs_out_if;
	logic                           valid;
	logic                           ready;
	logic [hhcs_pkg::COUNT_BITS-1:0] count;
	logic                           is_chain;

	modport source (
		output valid, count, is_chain,
		input  ready
	);
	modport sink (
		input  valid, count, is_chain,
		output ready
	);
endinterface
`default_nettype wire

@@ hdl/hhcs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hhcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ hdl/hhcs_addr.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hhcs_addr (
	input  wire hhcs_pkg::item_t item,
	output hhcs_pkg::slot_t      slot
);

	logic       addr_ok;
	logic [2:0] pnl;
	logic [6:0] bin_v;
	int         sub;
	int         idx;
	int         bin_lin;
	int         chain_lin;

	always_comb begin
		pnl = (int'(item.panel) < hhcs_pkg::PANELS) ? item.panel : 3'd0;
		addr_ok = (int'(item.arm) < hhcs_pkg::ARMS) && (int'(item.gap) < hhcs_pkg::GAPS)
			&& (int'(item.panel) < hhcs_pkg::PANELS);

		if (item.action == hhcs_pkg::ACT_HIT) begin
			bin_v = (int'(item.pack_value) < hhcs_pkg::VALUE_BINS) ? item.pack_value
				: 7'(hhcs_pkg::VALUE_BINS);
		end else begin
			bin_v = item.bin_index;
		end

		// which of the panel's chains covers the value
		sub = ((int'(item.pack_value) >= hhcs_pkg::EDGE_A[item.orient][pnl]) ? 1 : 0)
			+ ((int'(item.pack_value) >= hhcs_pkg::EDGE_B[item.orient][pnl]) ? 1 : 0);

		if (item.action == hhcs_pkg::ACT_HIT) begin
			idx = int'(item.gap) * hhcs_pkg::PER_GAP[item.orient]
				+ hhcs_pkg::PANEL_BASE[item.orient][pnl] + sub;
		end else begin
			idx = int'(item.chain_index);
		end

		bin_lin = (((int'(item.arm) * hhcs_pkg::GAPS + int'(item.gap)) * hhcs_pkg::PANELS
			+ int'(pnl)) * hhcs_pkg::ORIENTS + int'(item.orient)) * hhcs_pkg::BINS_PER_HIST
			+ int'(bin_v);
		chain_lin = int'(item.arm) * hhcs_pkg::CHAINS_PER_ARM
			+ int'(item.orient) * (hhcs_pkg::GAPS * hhcs_pkg::H_PER_GAP) + idx;

		slot.bin_addr   = hhcs_pkg::BIN_AW'(bin_lin);
		slot.chain_addr = hhcs_pkg::CHAIN_AW'(chain_lin);

		if (item.action == hhcs_pkg::ACT_HIT) begin
			slot.bin_ok   = addr_ok;
			slot.chain_ok = addr_ok && (int'(item.pack_value) < hhcs_pkg::VALUE_BINS - 1);
		end else begin
			slot.bin_ok   = addr_ok && (int'(item.bin_index) <= hhcs_pkg::VALUE_BINS);
			slot.chain_ok = (int'(item.arm) < hhcs_pkg::ARMS)
				&& (int'(item.chain_index) < hhcs_pkg::GAPS * hhcs_pkg::PER_GAP[item.orient]);
		end
	end

endmodule
`default_nettype wire

@@ hdl/hit_histogram_with_chain_sums.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Hit histogram with chain sums. Each hit word bumps one saturating bin counter and,
// for values below 65, the counter of the supply chain that covers it; read words
// return one bin or chain count. Both counter sets live in single-port-write RAMs
// with a registered read. A word goes through accept, RAM read and update or result,
// and no new word is taken until it is done; a read result waits for a free output
// register and then stays there while the next word is taken. After reset the block
// clears both RAMs one entry a cycle and takes no word until every bin entry is clear.
module hit_histogram_with_chain_sums (
	input wire logic clk,
	input wire logic arst_n,
	hhcs_in_if.sink  hit,
	hhcs_out_if.source result
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [hhcs_pkg::BIN_AW-1:0]   clr_q;
	hhcs_pkg::item_t               item_q;
	hhcs_pkg::slot_t               slot;
	logic                          out_valid_q;
	hhcs_pkg::count_t              count_q;
	logic                          is_chain_q;

	logic                          bin_we;
	logic [hhcs_pkg::BIN_AW-1:0]   bin_waddr;
	hhcs_pkg::count_t              bin_wdata;
	hhcs_pkg::count_t              bin_rdata;
	logic                          chain_we;
	logic [hhcs_pkg::CHAIN_AW-1:0] chain_waddr;
	hhcs_pkg::count_t              chain_wdata;
	hhcs_pkg::count_t              chain_rdata;
	logic                          is_hit;
	logic                          out_free;
	logic                          out_load;

	hhcs_addr u_addr (
		.item (item_q),
		.slot (slot)
	);

	hhcs_ram #(
		.WIDTH (hhcs_pkg::COUNT_BITS),
		.DEPTH (hhcs_pkg::BIN_DEPTH)
	) u_bin_ram (
		.clk   (clk),
		.we    (bin_we),
		.waddr (bin_waddr),
		.wdata (bin_wdata),
		.raddr (slot.bin_addr),
		.rdata (bin_rdata)
	);

	hhcs_ram #(
		.WIDTH (hhcs_pkg::COUNT_BITS),
		.DEPTH (hhcs_pkg::CHAIN_DEPTH)
	) u_chain_ram (
		.clk   (clk),
		.we    (chain_we),
		.waddr (chain_waddr),
		.wdata (chain_wdata),
		.raddr (slot.chain_addr),
		.rdata (chain_rdata)
	);

	assign is_hit   = (item_q.action == hhcs_pkg::ACT_HIT);
	assign out_free = !out_valid_q || result.ready;
	assign out_load = (state_q == ST_DONE) && out_free
		&& (item_q.action == hhcs_pkg::ACT_BIN || item_q.action == hhcs_pkg::ACT_CHAIN);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			bin_we      = 1'b1;
			bin_waddr   = clr_q;
			bin_wdata   = '0;
			chain_we    = (int'(clr_q) < hhcs_pkg::CHAIN_DEPTH);
			chain_waddr = clr_q[hhcs_pkg::CHAIN_AW-1:0];
			chain_wdata = '0;
		end else begin
			bin_we      = (state_q == ST_DONE) && is_hit && slot.bin_ok;
			bin_waddr   = slot.bin_addr;
			// saturating increment
			bin_wdata   = (bin_rdata == '1) ? bin_rdata : bin_rdata + 1'b1;
			chain_we    = (state_q == ST_DONE) && is_hit && slot.chain_ok;
			chain_waddr = slot.chain_addr;
			chain_wdata = (chain_rdata == '1) ? chain_rdata : chain_rdata + 1'b1;
		end
	end

	assign hit.ready       = (state_q == ST_IDLE);
	assign result.valid    = out_valid_q;
	assign result.count    = count_q;
	assign result.is_chain = is_chain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			is_chain_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (int'(clr_q) == hhcs_pkg::BIN_DEPTH - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (hit.valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (item_q.action == hhcs_pkg::ACT_BIN
						|| item_q.action == hhcs_pkg::ACT_CHAIN) begin
						// hold the read until the output register can take the word
						if (out_free) begin
							is_chain_q  <= (item_q.action == hhcs_pkg::ACT_CHAIN);
							if (item_q.action == hhcs_pkg::ACT_CHAIN) begin
								count_q <= slot.chain_ok ? chain_rdata : '0;
							end else begin
								count_q <= slot.bin_ok ? bin_rdata : '0;
							end
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hit.valid && hit.ready) begin
			item_q.action      <= hit.action;
			item_q.arm         <= hit.arm;
			item_q.gap         <= hit.gap;
			item_q.panel       <= hit.panel;
			item_q.orient      <= hit.orient;
			item_q.pack_value  <= hit.pack_value;
			item_q.bin_index   <= hit.bin_index;
			item_q.chain_index <= hit.chain_index;
		end
	end

endmodule
`default_nettype wire
